/* src/ptst_pkg.sv */
// ----------------------------------------------------------------------------
// ptst_pkg
// Types and constants shared by the periodic timer slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package ptst_pkg;

    localparam int SLOTS_DEFAULT      = 32;
    localparam int COUNT_BITS_DEFAULT = 32;
    localparam int SLOT_ID_W          = 8;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic REPLY_FIRE = 1'b0;
    localparam logic REPLY_ADD  = 1'b1;

    typedef struct packed {
        logic [1:0]           kind;
        logic [31:0]          start_count;
        logic [31:0]          reload_period;
        logic [SLOT_ID_W-1:0] remove_id;
    } in_req_t;

    typedef struct packed {
        logic                 reply_kind;
        logic [SLOT_ID_W-1:0] slot_id;
        logic                 last;
    } out_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_TICK_RD,
        ST_TICK_EX,
        ST_TICK_END
    } state_t;

endpackage

`default_nettype wire

/* src/periodic_timer_slot_table.sv */
// ----------------------------------------------------------------------------
// periodic_timer_slot_table
// Table of periodic timer slots held in two memories with registered reads.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready/in_data, results leave on
// out_valid/out_ready/out_data, both valid/ready handshakes.
// A remove request is handled in the cycle it is accepted and gives no result.
// An add request scans the vacancy bits one slot per cycle from slot 1, and
// at the lowest vacant slot (or at once, with id 0, when full) its reply is
// loaded into the output register when that register is free.
// A tick sweeps all SLOTS slots through the countdown memory: a vacant slot
// is skipped, an occupied slot is read in ST_TICK_RD, then updated and
// written back in ST_TICK_EX, and ST_TICK_END closes the sweep.
// A fired id is held back one step so that the final one carries last.
// in_ready is high only when no request is in progress; one finished result
// may wait in the output register while the next request is accepted.
// When out_ready stays low the sweep halts at a firing slot with a held-back
// id to pass on until the output register is free; nothing is dropped.
// Reset marks every slot vacant; the memories need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_slot_table #(
    parameter int SLOTS      = ptst_pkg::SLOTS_DEFAULT,
    parameter int COUNT_BITS = ptst_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ptst_pkg::in_req_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ptst_pkg::out_req_t     out_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int ID_W  = ptst_pkg::SLOT_ID_W;

    ptst_pkg::state_t state_reg, state_next;

    ptst_pkg::in_req_t   req_reg;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [SLOTS-1:0]    vacant_reg, vacant_next;
    logic [CNT_W-1:0]    vcount_reg, vcount_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]     pend_id_reg, pend_id_next;
    logic                out_valid_reg, out_valid_next;
    ptst_pkg::out_req_t  out_reg;

    logic [COUNT_BITS-1:0] countdown_mem [SLOTS];
    logic [COUNT_BITS-1:0] period_mem [SLOTS];
    logic [COUNT_BITS-1:0] cnt_rdata_reg;
    logic [COUNT_BITS-1:0] per_rdata_reg;

    logic                  rd_en;
    logic                  cnt_we;
    logic                  per_we;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  emit;
    ptst_pkg::out_req_t    emit_data;

    logic                  accept;
    logic                  can_emit;
    logic                  idx_at_end;
    logic                  fire;
    logic [ID_W-1:0]       idx_id;
    logic [ID_W-1:0]       rid_m1;
    logic [IDX_W-1:0]      rid_idx;
    logic                  rid_ok;

    assign in_ready   = (state_reg == ptst_pkg::ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign can_emit   = !out_valid_reg || out_ready;
    assign idx_at_end = (idx_reg == IDX_W'(SLOTS - 1));
    assign fire       = (cnt_rdata_reg == '0);
    assign idx_id     = ID_W'(idx_reg) + ID_W'(1);
    assign rid_m1     = in_data.remove_id - ID_W'(1);
    assign rid_idx    = IDX_W'(rid_m1);
    assign rid_ok     = (in_data.remove_id != '0) && (in_data.remove_id <= ID_W'(SLOTS));

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptst_pkg::ST_IDLE:
            begin
                if (accept && in_data.kind == ptst_pkg::KIND_TICK)
                    state_next = ptst_pkg::ST_TICK_RD;
                else if (accept && in_data.kind == ptst_pkg::KIND_ADD)
                    state_next = ptst_pkg::ST_ADD;
            end
            ptst_pkg::ST_ADD:
            begin
                if ((vcount_reg == '0 || vacant_reg[idx_reg]) && can_emit)
                    state_next = ptst_pkg::ST_IDLE;
            end
            ptst_pkg::ST_TICK_RD:
            begin
                if (!vacant_reg[idx_reg])
                    state_next = ptst_pkg::ST_TICK_EX;
                else if (idx_at_end)
                    state_next = ptst_pkg::ST_TICK_END;
            end
            ptst_pkg::ST_TICK_EX:
            begin
                if (!(fire && pend_valid_reg && !can_emit))
                    state_next = idx_at_end ? ptst_pkg::ST_TICK_END : ptst_pkg::ST_TICK_RD;
            end
            ptst_pkg::ST_TICK_END:
            begin
                if (!pend_valid_reg || can_emit)
                    state_next = ptst_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ptst_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb
    begin
        idx_next        = idx_reg;
        vacant_next     = vacant_reg;
        vcount_next     = vcount_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        rd_en           = 1'b0;
        cnt_we          = 1'b0;
        per_we          = 1'b0;
        cnt_wdata       = req_reg.start_count[COUNT_BITS-1:0];
        emit            = 1'b0;
        emit_data       = '0;
        unique case (state_reg)
            ptst_pkg::ST_IDLE:
            begin
                idx_next        = '0;
                pend_valid_next = 1'b0;
                if (accept && in_data.kind == ptst_pkg::KIND_REMOVE && rid_ok
                    && !vacant_reg[rid_idx])
                begin
                    vacant_next[rid_idx] = 1'b1;
                    vcount_next          = vcount_reg + CNT_W'(1);
                end
            end
            ptst_pkg::ST_ADD:
            begin
                if (vcount_reg == '0)
                begin
                    emit      = can_emit;
                    emit_data = '{reply_kind: ptst_pkg::REPLY_ADD, slot_id: '0, last: 1'b1};
                end
                else if (vacant_reg[idx_reg])
                begin
                    if (can_emit)
                    begin
                        emit                 = 1'b1;
                        emit_data            = '{reply_kind: ptst_pkg::REPLY_ADD,
                                                 slot_id: idx_id, last: 1'b1};
                        cnt_we               = 1'b1;
                        per_we               = 1'b1;
                        vacant_next[idx_reg] = 1'b0;
                        vcount_next          = vcount_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ptst_pkg::ST_TICK_RD:
            begin
                if (!vacant_reg[idx_reg])
                    rd_en = 1'b1;
                else if (!idx_at_end)
                    idx_next = idx_reg + IDX_W'(1);
            end
            ptst_pkg::ST_TICK_EX:
            begin
                cnt_wdata = (fire ? per_rdata_reg : cnt_rdata_reg) - COUNT_BITS'(1);
                if (!(fire && pend_valid_reg && !can_emit))
                begin
                    cnt_we = 1'b1;
                    if (fire)
                    begin
                        emit            = pend_valid_reg;
                        emit_data       = '{reply_kind: ptst_pkg::REPLY_FIRE,
                                            slot_id: pend_id_reg, last: 1'b0};
                        pend_valid_next = 1'b1;
                        pend_id_next    = idx_id;
                    end
                    if (!idx_at_end)
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            ptst_pkg::ST_TICK_END:
            begin
                if (pend_valid_reg && can_emit)
                begin
                    emit            = 1'b1;
                    emit_data       = '{reply_kind: ptst_pkg::REPLY_FIRE,
                                        slot_id: pend_id_reg, last: 1'b1};
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ptst_pkg::ST_IDLE;
            idx_reg        <= '0;
            vacant_reg     <= '1;
            vcount_reg     <= CNT_W'(SLOTS);
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            vacant_reg     <= vacant_next;
            vcount_reg     <= vcount_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg <= pend_id_next;
        if (accept)
            req_reg <= in_data;
        if (emit)
            out_reg <= emit_data;
    end

    // countdown memory
    always_ff @(posedge clk)
    begin
        if (cnt_we)
            countdown_mem[idx_reg] <= cnt_wdata;
        if (rd_en)
            cnt_rdata_reg <= countdown_mem[idx_reg];
    end

    // period memory
    always_ff @(posedge clk)
    begin
        if (per_we)
            period_mem[idx_reg] <= req_reg.reload_period[COUNT_BITS-1:0];
        if (rd_en)
            per_rdata_reg <= period_mem[idx_reg];
    end

endmodule

`default_nettype wire

/* sim/periodic_timer_slot_table_test.sv */
// ----------------------------------------------------------------------------
// periodic_timer_slot_table_test
// Self-checking bench for the periodic timer slot table. Add, remove, tick
// and unused requests go in through a valid/ready port. A local model of
// the slot table predicts every add reply and every fired slot. A checker
// compares each result, field by field, with the oldest prediction. The
// run covers directed corner cases, a full table, a long output stall and
// three random phases with different idle mixes on both ports.
// ----------------------------------------------------------------------------
module periodic_timer_slot_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         NUM_SLOTS     = ptst_pkg::SLOTS_DEFAULT;
    localparam int         CNT_W         = ptst_pkg::COUNT_BITS_DEFAULT;
    localparam int         ID_W          = ptst_pkg::SLOT_ID_W;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         TOTAL_ITEMS   = 460;
    localparam int         SETTLE_CYCLES = 4 * NUM_SLOTS + 20;
    localparam int         CYCLE_LIMIT   = 2_000_000;
    localparam int         HOLD_STRETCH  = 600;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    ptst_pkg::in_req_t  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    ptst_pkg::out_req_t out_data;

    logic [CNT_W-1:0]   slot_count  [NUM_SLOTS];
    logic [CNT_W-1:0]   slot_period [NUM_SLOTS];
    bit                 slot_busy   [NUM_SLOTS];
    int                 busy_total   = 0;
    ptst_pkg::out_req_t expected_replies [$];

    int send_idle_pct = 35;
    int recv_idle_pct = 69;
    int hold_cycles   = 0;
    int items_sent    = 0;
    int table_changes = 0;
    int adds_sent     = 0;
    int full_adds     = 0;
    int fires_seen    = 0;
    int replies_seen  = 0;
    int error_count   = 0;
    int cycle_count   = 0;

    periodic_timer_slot_table #(
        .SLOTS      (NUM_SLOTS),
        .COUNT_BITS (CNT_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(string msg);
        error_count++;
        $display("%0t ns: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : check_results
        ptst_pkg::out_req_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_replies.size() == 0)
            begin
                report_mismatch($sformatf("result with none expected: kind %0d id %0d",
                                          out_data.reply_kind, out_data.slot_id));
            end
            else
            begin
                want = expected_replies.pop_front();
                if (out_data.reply_kind !== want.reply_kind)
                    report_mismatch($sformatf("reply_kind expected %0d got %0d",
                                              want.reply_kind, out_data.reply_kind));
                if (out_data.slot_id !== want.slot_id)
                    report_mismatch($sformatf("slot_id expected %0d got %0d",
                                              want.slot_id, out_data.slot_id));
                if (out_data.last !== want.last)
                    report_mismatch($sformatf("last expected %0d got %0d (slot %0d)",
                                              want.last, out_data.last, want.slot_id));
                if (want.reply_kind == ptst_pkg::REPLY_FIRE)
                    fires_seen++;
                else
                    replies_seen++;
            end
        end
    end

    // slot table model; returns 1 for every tick and add and for a remove that frees a slot
    function automatic bit predict_request(ptst_pkg::in_req_t req);
        int                 fired [$];
        int                 slot;
        ptst_pkg::out_req_t rsp;
        bit                 effective;
        effective = 1'b0;
        case (req.kind)
            ptst_pkg::KIND_TICK:
            begin
                effective = 1'b1;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (slot_busy[i])
                    begin
                        if (slot_count[i] == '0)
                        begin
                            fired.push_back(i + 1);
                            slot_count[i] = slot_period[i];
                        end
                        slot_count[i] = slot_count[i] - CNT_W'(1);
                    end
                end
                foreach (fired[k])
                begin
                    rsp.reply_kind = ptst_pkg::REPLY_FIRE;
                    rsp.slot_id    = ID_W'(fired[k]);
                    rsp.last       = (k == fired.size() - 1);
                    expected_replies.push_back(rsp);
                end
            end
            ptst_pkg::KIND_ADD:
            begin
                effective = 1'b1;
                adds_sent++;
                slot = -1;
                for (int i = 0; i < NUM_SLOTS && slot < 0; i++)
                    if (!slot_busy[i])
                        slot = i;
                rsp.reply_kind = ptst_pkg::REPLY_ADD;
                rsp.last       = 1'b1;
                if (slot < 0)
                begin
                    rsp.slot_id = '0;
                    full_adds++;
                end
                else
                begin
                    slot_count[slot]  = req.start_count[CNT_W-1:0];
                    slot_period[slot] = req.reload_period[CNT_W-1:0];
                    slot_busy[slot]   = 1'b1;
                    busy_total++;
                    rsp.slot_id = ID_W'(slot + 1);
                end
                expected_replies.push_back(rsp);
            end
            ptst_pkg::KIND_REMOVE:
            begin
                if (req.remove_id != 0 && req.remove_id <= NUM_SLOTS)
                begin
                    if (slot_busy[req.remove_id - 1])
                    begin
                        slot_busy[req.remove_id - 1] = 1'b0;
                        busy_total--;
                        effective = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return effective;
    endfunction

    task automatic send_request(ptst_pkg::in_req_t req);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        if (predict_request(req))
            table_changes++;
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
    endtask

    // unused fields carry random bits
    function automatic ptst_pkg::in_req_t noise_request(logic [1:0] kind);
        ptst_pkg::in_req_t req;
        req.kind          = kind;
        req.start_count   = $urandom;
        req.reload_period = $urandom;
        req.remove_id     = ID_W'($urandom);
        return req;
    endfunction

    task automatic send_tick();
        send_request(noise_request(ptst_pkg::KIND_TICK));
    endtask

    task automatic send_unused();
        send_request(noise_request(KIND_UNUSED));
    endtask

    task automatic send_add(logic [31:0] start, logic [31:0] period);
        ptst_pkg::in_req_t req;
        req = noise_request(ptst_pkg::KIND_ADD);
        req.start_count   = start;
        req.reload_period = period;
        send_request(req);
    endtask

    task automatic send_remove(logic [7:0] id);
        ptst_pkg::in_req_t req;
        req = noise_request(ptst_pkg::KIND_REMOVE);
        req.remove_id = id;
        send_request(req);
    endtask

    task automatic clear_table();
        for (int i = 1; i <= NUM_SLOTS; i++)
            send_remove(i[7:0]);
    endtask

    // mostly short counts so slots keep firing
    function automatic logic [31:0] pick_count();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom_range(5);
        endcase
    endfunction

    function automatic logic [7:0] pick_remove_id();
        int roll;
        int slot;
        roll = $urandom_range(99);
        if (roll < 75 && busy_total > 0)
        begin
            do
                slot = $urandom_range(NUM_SLOTS - 1);
            while (!slot_busy[slot]);
            return 8'(slot + 1);
        end
        if (roll < 85)
            return 8'($urandom_range(NUM_SLOTS, 1));
        if (roll < 92)
            return 8'd0;
        return 8'($urandom_range(255, NUM_SLOTS + 1));
    endfunction

    task automatic test_ignored_requests();
        send_tick();
        send_remove(8'd0);
        send_remove(8'(NUM_SLOTS + 1));
        send_remove(8'd255);
        send_remove(8'd1);
        send_unused();
        wait_idle();
    endtask

    task automatic test_add_and_fire();
        send_add(32'd0, 32'd0);
        send_add(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_add(32'd1, 32'd1);
        send_add(32'd0, 32'd2);
        repeat (3) send_tick();
        send_remove(8'd2);
        send_add(32'd5, 32'd0);
        send_remove(8'd3);
        send_remove(8'd3);
        send_tick();
        send_add(32'hAAAA_AAAA, 32'h5555_5555);
        wait_idle();
    endtask

    task automatic test_full_table();
        clear_table();
        for (int i = 0; i < NUM_SLOTS; i++)
            send_add(i % 3, i % 4);
        send_add($urandom, $urandom);
        send_add(32'd0, 32'd0);
        repeat (3) send_tick();
        send_remove(8'd7);
        send_remove(8'd20);
        send_add(32'd1, 32'd2);
        send_add(32'd3, 32'd0);
        send_add(32'd0, 32'd1);
        send_tick();
        clear_table();
        wait_idle();
    endtask

    // every tick fires half the table while the result side is held off
    task automatic test_back_pressure();
        clear_table();
        for (int i = 0; i < NUM_SLOTS / 2; i++)
            send_add(32'd0, 32'd1);
        wait_idle();
        hold_cycles = HOLD_STRETCH;
        repeat (6) send_tick();
        wait_idle();
        clear_table();
        wait_idle();
    endtask

    task automatic run_random(int target);
        int roll;
        while (items_sent < target)
        begin
            roll = $urandom_range(99);
            if (roll < 35)
                send_tick();
            else if (roll < 70)
                send_add(pick_count(), pick_count());
            else if (roll < 95)
                send_remove(pick_remove_id());
            else
                send_unused();
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_ignored_requests();
        test_add_and_fire();
        test_full_table();
        run_random(200);

        send_idle_pct = 69;
        recv_idle_pct = 35;
        test_back_pressure();
        run_random(330);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(TOTAL_ITEMS);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_replies.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_replies.size()));

        $display("run covered %0d requests, %0d of them table-changing: %0d adds (%0d full)",
                 items_sent, table_changes, adds_sent, full_adds);
        $display("checked %0d add replies and %0d fired slots, %0d mismatches",
                 replies_seen, fires_seen, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
